FILE: design/isort_pkg.sv
package isort_pkg;

  // Number of entries the sorted store can hold.
  localparam int DEPTH = 16;
  // Count width holds 0..DEPTH, index width addresses 0..DEPTH-1.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               dropped;
  } out_t;

endpackage

FILE: design/insertion_sorter.sv
// Insertion sorter for sets of signed 32-bit values.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one value per transfer,
// with the last flag marking the final value of a set. Output channel
// (out_valid_o / out_ready_i / out_data_o): after the last value of a set has
// been inserted, every stored entry is sent in ascending order, the final
// one flagged by final_res and each one carrying dropped when a value of the
// set arrived while the store already held DEPTH entries.
//
// Insertion walks down the store from the top, one entry per cycle through
// a memory with one write port and one registered read port: an item goes
// straight to S_PLACE in an empty store, else S_SHIFT moves each greater
// entry up before S_PLACE writes it. A value arriving at a full store is
// dropped. Emitting reads the first entry, then loads each result into
// the result register; a stalled receiver simply holds it and the walk.
// The block takes no new input until a set has been fully emitted.
//
// Reset clears the entry count and the drop flag; store contents are left
// as they are and are only read after they have been written.
module insertion_sorter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  isort_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output isort_pkg::out_t out_data_o
);
  import isort_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               ovf_q, ovf_d;
  logic signed [31:0] val_q, val_d;
  logic               last_q, last_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // The sorted store and its registered read port.
  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rdata_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_data;

  logic in_xfer;
  logic out_xfer;
  logic is_full;
  logic shift_up;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;
  assign is_full     = (count_q == CNT_W'(DEPTH));
  // Only strictly greater entries move, so equal values keep arrival order.
  assign shift_up    = (rdata_q > val_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    val_d       = val_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_addr     = '0;
    mem_we      = 1'b0;
    wr_addr     = pos_q[IDX_W-1:0];
    wr_data     = val_q;

    unique case (state_q)
      S_IDLE: begin
        // Fetch the current top entry so the walk can start next cycle.
        rd_addr = IDX_W'(count_q - CNT_W'(1));
        if (in_xfer) begin
          val_d  = in_data_i.value;
          last_d = in_data_i.last;
          idx_d  = '0;
          if (is_full) begin
            ovf_d   = 1'b1;
            state_d = in_data_i.last ? S_EMIT_RD : S_IDLE;
          end else if (count_q == '0) begin
            pos_d   = '0;
            state_d = S_PLACE;
          end else begin
            pos_d   = count_q;
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // rdata_q holds the entry just below the gap at pos_q.
        rd_addr = IDX_W'(pos_q - CNT_W'(2));
        if (shift_up) begin
          mem_we  = 1'b1;
          wr_data = rdata_q;
          pos_d   = pos_q - CNT_W'(1);
          if (pos_q == CNT_W'(1)) begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_PLACE;
        end
      end

      S_PLACE: begin
        mem_we  = 1'b1;
        count_d = count_q + CNT_W'(1);
        state_d = last_q ? S_EMIT_RD : S_IDLE;
      end

      S_EMIT_RD: begin
        rd_addr = idx_q;
        state_d = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        rd_addr                = idx_q + IDX_W'(1);
        out_d.sorted_value     = rdata_q;
        out_d.final_res        = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
        out_d.dropped          = ovf_q;
        out_valid_d            = 1'b1;
        state_d                = S_EMIT_WAIT;
      end

      S_EMIT_WAIT: begin
        // Keep reading the next entry so it is ready when this one leaves.
        rd_addr = idx_q + IDX_W'(1);
        if (out_xfer) begin
          out_valid_d = 1'b0;
          if (out_q.final_res) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_EMIT_LD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

endmodule

FILE: design/isort_checker.sv
module isort_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input isort_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input isort_pkg::out_t out_data_o
);
  import isort_pkg::*;

  // The block never takes input while a result is waiting.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // After a result that is not the final one, the set is still being emitted.
  a_busy_mid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.final_res) |=> !in_ready_o)
    else $error("input ready in the middle of a set");

  // Once the final result of a set leaves, the block is ready for a new set.
  a_ready_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.final_res) |=> in_ready_o)
    else $error("not ready after the final result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or withdrawn");

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);
